// ===== rtl/core/tbd_pkg.sv =====
// ---------------------------------------------------------------------------
// Twin thruster boat dynamics package
// Shared widths, fixed-point constants, CORDIC angle table, register codes
// and the sideband record that rides along the pipeline.
// ---------------------------------------------------------------------------
package tbd_pkg;

  // Fixed-point fraction bits of positions, velocities, angles and gains
  localparam int FRAC_BITS = 16;

  // Field widths
  localparam int POS_W   = 32;
  localparam int HEAD_W  = 19;
  localparam int VEL_W   = 24;
  localparam int THR_W   = 16;
  localparam int SWV_W   = 17;

  // Configuration port
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 3;
  localparam int DT_W      = 16;
  localparam int GAIN_W    = 20;
  localparam int DECAY_W   = 16;

  localparam logic [DT_W-1:0]    STEP_TIME_RST   = 16'd6554;
  localparam logic [GAIN_W-1:0]  SURGE_GAIN_RST  = 20'd32768;
  localparam logic [GAIN_W-1:0]  SWAY_GAIN_RST   = 20'd32768;
  localparam logic [GAIN_W-1:0]  YAW_LEN_RST     = 20'd220415;
  localparam logic [GAIN_W-1:0]  YAW_WID_RST     = 20'd44083;
  localparam logic [DECAY_W-1:0] SURGE_DECAY_RST = 16'd1193;
  localparam logic [DECAY_W-1:0] SWAY_DECAY_RST  = 16'd1199;
  localparam logic [DECAY_W-1:0] YAW_DECAY_RST   = 16'd17618;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_TIME   = 3'd0,
    REG_SURGE_GAIN  = 3'd1,
    REG_SWAY_GAIN   = 3'd2,
    REG_YAW_LEN     = 3'd3,
    REG_YAW_WID     = 3'd4,
    REG_SURGE_DECAY = 3'd5,
    REG_SWAY_DECAY  = 3'd6,
    REG_YAW_DECAY   = 3'd7
  } cfg_reg_t;

  // Angle constants, Q2.30 and Q3.F
  localparam longint PI_Q30          = 64'sd3373259426;
  localparam longint HALF_PI_Q30     = 64'sd1686629713;
  localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;
  localparam int     Q30_SHIFT       = 30 - FRAC_BITS;
  localparam longint P_FIX  = (PI_Q30 + (64'sd1 <<< (Q30_SHIFT - 1))) >>> Q30_SHIFT;
  localparam longint TP_FIX = 2 * P_FIX;

  // Reciprocal of two pi for the heading wrap: quotient = (b * RECIP) >> RECIP_SHIFT
  localparam int     RECIP_SHIFT = 40;
  localparam longint RECIP       = (64'sd1 <<< RECIP_SHIFT) / TP_FIX;

  // CORDIC
  localparam int CW              = 34;
  localparam int SC_W            = 32;
  localparam int CORDIC_STEPS    = 30;
  localparam int ITERS_PER_STAGE = 2;
  localparam int CORDIC_STAGES   = CORDIC_STEPS / ITERS_PER_STAGE;
  localparam int CORDIC_LAT      = CORDIC_STAGES + 2;

  // Arithmetic tail after the CORDIC
  localparam int TAIL_STAGES = 5;
  localparam int PIPE_DEPTH  = CORDIC_LAT + TAIL_STAGES;

  typedef logic signed [CW-1:0] cw_t;

  localparam cw_t ATAN_Q30 [CORDIC_STEPS] = '{
    34'sh3243F6A8, 34'sh1DAC6705, 34'sh0FADBAFC, 34'sh07F56EA6, 34'sh03FEAB76,
    34'sh01FFD55B, 34'sh00FFFAAA, 34'sh007FFF55, 34'sh003FFFEA, 34'sh001FFFFD,
    34'sh000FFFFF, 34'sh0007FFFF, 34'sh0003FFFF, 34'sh0001FFFF, 34'sh0000FFFF,
    34'sh00007FFF, 34'sh00003FFF, 34'sh00001FFF, 34'sh00000FFF, 34'sh000007FF,
    34'sh000003FF, 34'sh000001FF, 34'sh000000FF, 34'sh0000007F, 34'sh0000003F,
    34'sh0000001F, 34'sh0000000F, 34'sh00000008, 34'sh00000004, 34'sh00000002
  };

  // Vessel state and thrust that travel beside the CORDIC
  typedef struct packed {
    logic signed [POS_W-1:0]  px;
    logic signed [POS_W-1:0]  py;
    logic signed [HEAD_W-1:0] h;
    logic signed [VEL_W-1:0]  u;
    logic signed [VEL_W-1:0]  v;
    logic signed [VEL_W-1:0]  r;
    logic signed [THR_W-1:0]  tl;
    logic signed [THR_W-1:0]  tr;
  } sb_t;

endpackage

// ===== rtl/core/tbd_cordic.sv =====
// ---------------------------------------------------------------------------
// Pipelined sine/cosine
// Wraps the angle to [-pi, pi), folds it into [-pi/2, pi/2], runs the
// rotation-mode CORDIC two iterations per stage and unfolds the sign.
// ---------------------------------------------------------------------------
module tbd_cordic
  import tbd_pkg::*;
(
  input  logic                     clk,
  input  logic [CORDIC_LAT-1:0]    en,
  input  logic signed [HEAD_W-1:0] angle,
  output logic signed [SC_W-1:0]   sin_o,
  output logic signed [SC_W-1:0]   cos_o
);

  localparam int AW = HEAD_W + 2;
  localparam logic signed [AW-1:0] P_A  = AW'(P_FIX);
  localparam logic signed [AW-1:0] TP_A = AW'(TP_FIX);
  localparam cw_t HALF_C = CW'(HALF_PI_Q30);
  localparam cw_t PI_C   = CW'(PI_Q30);

  logic signed [AW-1:0] a_ext, a_wrap;
  cw_t  z_in, z_fold;
  logic flip_in;

  cw_t  x_r    [CORDIC_STAGES+1];
  cw_t  y_r    [CORDIC_STAGES+1];
  cw_t  z_r    [CORDIC_STAGES+1];
  logic flip_r [CORDIC_STAGES+1];

  // Wrap once into [-pi, pi), then fold into the right half plane
  always_comb begin
    a_ext = AW'(angle);
    if (a_ext >= P_A) begin
      a_wrap = a_ext - TP_A;
    end else if (a_ext < -P_A) begin
      a_wrap = a_ext + TP_A;
    end else begin
      a_wrap = a_ext;
    end
    z_in = CW'(a_wrap) <<< Q30_SHIFT;
    if (z_in > HALF_C) begin
      z_fold  = z_in - PI_C;
      flip_in = 1'b1;
    end else if (z_in < -HALF_C) begin
      z_fold  = z_in + PI_C;
      flip_in = 1'b1;
    end else begin
      z_fold  = z_in;
      flip_in = 1'b0;
    end
  end

  // Load the start vector
  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_r[0]    <= CW'(CORDIC_GAIN_Q30);
      y_r[0]    <= '0;
      z_r[0]    <= z_fold;
      flip_r[0] <= flip_in;
    end
  end

  // Rotation stages
  for (genvar j = 1; j <= CORDIC_STAGES; j++) begin : g_stage
    cw_t xs [ITERS_PER_STAGE+1];
    cw_t ys [ITERS_PER_STAGE+1];
    cw_t zs [ITERS_PER_STAGE+1];

    always_comb begin
      xs[0] = x_r[j-1];
      ys[0] = y_r[j-1];
      zs[0] = z_r[j-1];
      for (int k = 0; k < ITERS_PER_STAGE; k++) begin
        if (zs[k] >= 0) begin
          xs[k+1] = xs[k] - (ys[k] >>> ((j - 1) * ITERS_PER_STAGE + k));
          ys[k+1] = ys[k] + (xs[k] >>> ((j - 1) * ITERS_PER_STAGE + k));
          zs[k+1] = zs[k] - ATAN_Q30[(j - 1) * ITERS_PER_STAGE + k];
        end else begin
          xs[k+1] = xs[k] + (ys[k] >>> ((j - 1) * ITERS_PER_STAGE + k));
          ys[k+1] = ys[k] - (xs[k] >>> ((j - 1) * ITERS_PER_STAGE + k));
          zs[k+1] = zs[k] + ATAN_Q30[(j - 1) * ITERS_PER_STAGE + k];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        x_r[j]    <= xs[ITERS_PER_STAGE];
        y_r[j]    <= ys[ITERS_PER_STAGE];
        z_r[j]    <= zs[ITERS_PER_STAGE];
        flip_r[j] <= flip_r[j-1];
      end
    end
  end

  // Undo the fold
  always_ff @(posedge clk) begin
    if (en[CORDIC_LAT-1]) begin
      sin_o <= flip_r[CORDIC_STAGES] ? SC_W'(-y_r[CORDIC_STAGES])
                                     : SC_W'(y_r[CORDIC_STAGES]);
      cos_o <= flip_r[CORDIC_STAGES] ? SC_W'(-x_r[CORDIC_STAGES])
                                     : SC_W'(x_r[CORDIC_STAGES]);
    end
  end

endmodule

// ===== rtl/core/twin_thruster_boat_dynamics_step_top.sv =====
// ---------------------------------------------------------------------------
// Twin thruster boat dynamics step
// One explicit Euler step of a planar three-DOF vessel driven by two
// steerable thrusters, with linear damping, heading wrap and saturation.
// ---------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Payload
//  in      | sink      | in_valid / in_stall  | state + thruster command
//  out     | source    | out_valid / out_stall| next state
//  cfg     | sink      | cfg_we               | cfg_index, cfg_wdata
//
//  22 register stages: 17 for the three parallel CORDIC pipelines and 5 for
//  the multiply, round and saturate tail. One item enters every cycle while
//  in_stall is low.
//  Reset (synchronous, rst_n low) clears all valid bits and loads register
//  defaults. A stall on the output holds only the stages that are full; empty
//  stages keep filling, so in_stall rises only once the whole pipe is full.
// ---------------------------------------------------------------------------
module twin_thruster_boat_dynamics_step_top
  import tbd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,

  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [POS_W-1:0]  in_pos_x,
  input  logic signed [POS_W-1:0]  in_pos_y,
  input  logic signed [HEAD_W-1:0] in_heading,
  input  logic signed [VEL_W-1:0]  in_surge_vel,
  input  logic signed [VEL_W-1:0]  in_sway_vel,
  input  logic signed [VEL_W-1:0]  in_yaw_rate,
  input  logic signed [THR_W-1:0]  in_left_thrust,
  input  logic signed [THR_W-1:0]  in_right_thrust,
  input  logic signed [SWV_W-1:0]  in_left_angle,
  input  logic signed [SWV_W-1:0]  in_right_angle,

  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [POS_W-1:0]  out_next_pos_x,
  output logic signed [POS_W-1:0]  out_next_pos_y,
  output logic signed [HEAD_W-1:0] out_next_heading,
  output logic signed [VEL_W-1:0]  out_next_surge_vel,
  output logic signed [VEL_W-1:0]  out_next_sway_vel,
  output logic signed [VEL_W-1:0]  out_next_yaw_rate,

  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata
);

  // Stage indexes of the tail
  localparam int T1 = CORDIC_LAT;
  localparam int T2 = T1 + 1;
  localparam int T3 = T2 + 1;
  localparam int T4 = T3 + 1;
  localparam int T5 = T4 + 1;

  // Tail widths
  localparam int MT_W   = THR_W + SC_W;
  localparam int FS_W   = MT_W + 1;
  localparam int F_W    = FS_W - 15 + 1;
  localparam int MV_W   = VEL_W + SC_W;
  localparam int VS_W   = MV_W + 1;
  localparam int XD_W   = VS_W - 30 + 1;
  localparam int MD_W   = DECAY_W + 1 + VEL_W;
  localparam int RD_W   = MD_W - FRAC_BITS + 1;
  localparam int B_W    = RD_W + 1;
  localparam int GF_W   = GAIN_W + 1 + F_W;
  localparam int GR_W   = GF_W - 30 + 1;
  localparam int DX_W   = DT_W + 1 + XD_W;
  localparam int DR_W   = DX_W - FRAC_BITS + 1;
  localparam int RC_W   = 24;
  localparam int QP_W   = B_W + RC_W;
  localparam int Q_W    = QP_W - RECIP_SHIFT;
  localparam int RM_W   = B_W + 2;
  localparam int VSUM_W = GR_W + 3;
  localparam int PSUM_W = POS_W + 2;

  localparam logic signed [VSUM_W-1:0] V_HI = VSUM_W'((64'sd1 <<< (VEL_W - 1)) - 1);
  localparam logic signed [VSUM_W-1:0] V_LO = VSUM_W'(-(64'sd1 <<< (VEL_W - 1)));
  localparam logic signed [PSUM_W-1:0] P_HI = PSUM_W'((64'sd1 <<< (POS_W - 1)) - 1);
  localparam logic signed [PSUM_W-1:0] P_LO = PSUM_W'(-(64'sd1 <<< (POS_W - 1)));
  localparam logic signed [RM_W-1:0]   TP_R = RM_W'(TP_FIX);
  localparam logic signed [RM_W-1:0]   P_R  = RM_W'(P_FIX);

  // Configuration registers
  logic [DT_W-1:0]    cfg_step_time_r;
  logic [GAIN_W-1:0]  cfg_surge_gain_r, cfg_sway_gain_r, cfg_yaw_len_r, cfg_yaw_wid_r;
  logic [DECAY_W-1:0] cfg_surge_decay_r, cfg_sway_decay_r, cfg_yaw_decay_r;

  // Write the addressed register; drop unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_step_time_r   <= STEP_TIME_RST;
      cfg_surge_gain_r  <= SURGE_GAIN_RST;
      cfg_sway_gain_r   <= SWAY_GAIN_RST;
      cfg_yaw_len_r     <= YAW_LEN_RST;
      cfg_yaw_wid_r     <= YAW_WID_RST;
      cfg_surge_decay_r <= SURGE_DECAY_RST;
      cfg_sway_decay_r  <= SWAY_DECAY_RST;
      cfg_yaw_decay_r   <= YAW_DECAY_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_STEP_TIME:   cfg_step_time_r   <= cfg_wdata[DT_W-1:0];
        REG_SURGE_GAIN:  cfg_surge_gain_r  <= cfg_wdata[GAIN_W-1:0];
        REG_SWAY_GAIN:   cfg_sway_gain_r   <= cfg_wdata[GAIN_W-1:0];
        REG_YAW_LEN:     cfg_yaw_len_r     <= cfg_wdata[GAIN_W-1:0];
        REG_YAW_WID:     cfg_yaw_wid_r     <= cfg_wdata[GAIN_W-1:0];
        REG_SURGE_DECAY: cfg_surge_decay_r <= cfg_wdata[DECAY_W-1:0];
        REG_SWAY_DECAY:  cfg_sway_decay_r  <= cfg_wdata[DECAY_W-1:0];
        REG_YAW_DECAY:   cfg_yaw_decay_r   <= cfg_wdata[DECAY_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage enables: a stage loads when it is empty or its successor moves
  logic [PIPE_DEPTH-1:0] vld_r;
  logic [PIPE_DEPTH-1:0] en;

  assign en[PIPE_DEPTH-1] = !vld_r[PIPE_DEPTH-1] || !out_stall;
  for (genvar k = 0; k < PIPE_DEPTH - 1; k++) begin : g_en
    assign en[k] = !vld_r[k] || en[k+1];
  end

  assign in_stall  = !en[0];
  assign out_valid = vld_r[PIPE_DEPTH-1];

  // Advance valid bits with each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // Sideband through the CORDIC stages and the first tail stages
  sb_t sb_r [T3+1];
  sb_t sb_in;

  assign sb_in = '{px: in_pos_x, py: in_pos_y, h: in_heading, u: in_surge_vel,
                   v: in_sway_vel, r: in_yaw_rate, tl: in_left_thrust,
                   tr: in_right_thrust};

  always_ff @(posedge clk) begin
    if (en[0]) sb_r[0] <= sb_in;
    for (int k = 1; k <= T3; k++) begin
      if (en[k]) sb_r[k] <= sb_r[k-1];
    end
  end

  // Sine and cosine of heading and both swivel angles
  logic signed [SC_W-1:0] sh, ch, sl, cl, sr, cr;

  tbd_cordic u_cordic_head (
    .clk   (clk),
    .en    (en[CORDIC_LAT-1:0]),
    .angle (in_heading),
    .sin_o (sh),
    .cos_o (ch)
  );

  tbd_cordic u_cordic_left (
    .clk   (clk),
    .en    (en[CORDIC_LAT-1:0]),
    .angle (HEAD_W'(in_left_angle)),
    .sin_o (sl),
    .cos_o (cl)
  );

  tbd_cordic u_cordic_right (
    .clk   (clk),
    .en    (en[CORDIC_LAT-1:0]),
    .angle (HEAD_W'(in_right_angle)),
    .sin_o (sr),
    .cos_o (cr)
  );

  // T1: thrust components, rotated velocities, damping and yaw step products
  logic signed [MT_W-1:0] t1_tlc_r, t1_trc_r, t1_tls_r, t1_trs_r;
  logic signed [MV_W-1:0] t1_uch_r, t1_vsh_r, t1_ush_r, t1_vch_r;
  logic signed [MD_W-1:0] t1_duu_r, t1_dvv_r, t1_drr_r, t1_dtr_r;
  sb_t sbc;

  assign sbc = sb_r[T1-1];

  always_ff @(posedge clk) begin
    if (en[T1]) begin
      t1_tlc_r <= MT_W'(sbc.tl) * MT_W'(cl);
      t1_trc_r <= MT_W'(sbc.tr) * MT_W'(cr);
      t1_tls_r <= MT_W'(sbc.tl) * MT_W'(sl);
      t1_trs_r <= MT_W'(sbc.tr) * MT_W'(sr);
      t1_uch_r <= MV_W'(sbc.u) * MV_W'(ch);
      t1_vsh_r <= MV_W'(sbc.v) * MV_W'(sh);
      t1_ush_r <= MV_W'(sbc.u) * MV_W'(sh);
      t1_vch_r <= MV_W'(sbc.v) * MV_W'(ch);
      t1_duu_r <= MD_W'($signed({1'b0, cfg_surge_decay_r})) * MD_W'(sbc.u);
      t1_dvv_r <= MD_W'($signed({1'b0, cfg_sway_decay_r})) * MD_W'(sbc.v);
      t1_drr_r <= MD_W'($signed({1'b0, cfg_yaw_decay_r})) * MD_W'(sbc.r);
      t1_dtr_r <= MD_W'($signed({1'b0, cfg_step_time_r})) * MD_W'(sbc.r);
    end
  end

  // T2: sum and round to working formats, start the heading sum
  logic signed [FS_W-1:0] fx_sum, fy_sum, fd_sum;
  logic signed [VS_W-1:0] xd_sum, yd_sum;
  logic signed [RD_W-1:0] hd;
  logic signed [F_W-1:0]  t2_fx_r, t2_fy_r, t2_fd_r;
  logic signed [XD_W-1:0] t2_xd_r, t2_yd_r;
  logic signed [RD_W-1:0] t2_duu_r, t2_dvv_r, t2_drr_r;
  logic signed [B_W-1:0]  t2_b_r;

  always_comb begin
    fx_sum = FS_W'(t1_tlc_r) + FS_W'(t1_trc_r);
    fy_sum = FS_W'(t1_tls_r) + FS_W'(t1_trs_r);
    fd_sum = FS_W'(t1_tlc_r) - FS_W'(t1_trc_r);
    xd_sum = VS_W'(t1_uch_r) - VS_W'(t1_vsh_r);
    yd_sum = VS_W'(t1_ush_r) + VS_W'(t1_vch_r);
    hd     = RD_W'(((t1_dtr_r >>> (FRAC_BITS - 1)) + 1) >>> 1);
  end

  always_ff @(posedge clk) begin
    if (en[T2]) begin
      t2_fx_r  <= F_W'(((fx_sum >>> 14) + 1) >>> 1);
      t2_fy_r  <= F_W'(((fy_sum >>> 14) + 1) >>> 1);
      t2_fd_r  <= F_W'(((fd_sum >>> 14) + 1) >>> 1);
      t2_xd_r  <= XD_W'(((xd_sum >>> 29) + 1) >>> 1);
      t2_yd_r  <= XD_W'(((yd_sum >>> 29) + 1) >>> 1);
      t2_duu_r <= RD_W'(((t1_duu_r >>> (FRAC_BITS - 1)) + 1) >>> 1);
      t2_dvv_r <= RD_W'(((t1_dvv_r >>> (FRAC_BITS - 1)) + 1) >>> 1);
      t2_drr_r <= RD_W'(((t1_drr_r >>> (FRAC_BITS - 1)) + 1) >>> 1);
      t2_b_r   <= B_W'(sb_r[T2-1].h) + B_W'(hd) + B_W'(P_FIX);
    end
  end

  // T3: gain products, position steps, heading quotient estimate
  logic signed [GF_W-1:0] t3_gfu_r, t3_gfv_r, t3_glf_r, t3_gwd_r;
  logic signed [DX_W-1:0] t3_dx_r, t3_dy_r;
  logic signed [QP_W-1:0] t3_qp_r;
  logic signed [B_W-1:0]  t3_b_r;
  logic signed [RD_W-1:0] t3_duu_r, t3_dvv_r, t3_drr_r;

  always_ff @(posedge clk) begin
    if (en[T3]) begin
      t3_gfu_r <= GF_W'($signed({1'b0, cfg_surge_gain_r})) * GF_W'(t2_fx_r);
      t3_gfv_r <= GF_W'($signed({1'b0, cfg_sway_gain_r})) * GF_W'(t2_fy_r);
      t3_glf_r <= GF_W'($signed({1'b0, cfg_yaw_len_r})) * GF_W'(t2_fy_r);
      t3_gwd_r <= GF_W'($signed({1'b0, cfg_yaw_wid_r})) * GF_W'(t2_fd_r);
      t3_dx_r  <= DX_W'($signed({1'b0, cfg_step_time_r})) * DX_W'(t2_xd_r);
      t3_dy_r  <= DX_W'($signed({1'b0, cfg_step_time_r})) * DX_W'(t2_yd_r);
      t3_qp_r  <= QP_W'(t2_b_r) * QP_W'(RECIP);
      t3_b_r   <= t2_b_r;
      t3_duu_r <= t2_duu_r;
      t3_dvv_r <= t2_dvv_r;
      t3_drr_r <= t2_drr_r;
    end
  end

  // T4: round, accumulate, take the heading remainder
  logic signed [GR_W-1:0]   gfu_rd, gfv_rd, glf_rd, gwd_rd;
  logic signed [DR_W-1:0]   dx_rd, dy_rd;
  logic signed [Q_W-1:0]    quo;
  logic signed [VSUM_W-1:0] t4_su_r, t4_sv_r, t4_sr_r;
  logic signed [PSUM_W-1:0] t4_sx_r, t4_sy_r;
  logic signed [RM_W-1:0]   t4_rem_r;
  sb_t sbt;

  assign sbt = sb_r[T3];

  always_comb begin
    gfu_rd = GR_W'(((t3_gfu_r >>> 29) + 1) >>> 1);
    gfv_rd = GR_W'(((t3_gfv_r >>> 29) + 1) >>> 1);
    glf_rd = GR_W'(((t3_glf_r >>> 29) + 1) >>> 1);
    gwd_rd = GR_W'(((t3_gwd_r >>> 29) + 1) >>> 1);
    dx_rd  = DR_W'(((t3_dx_r >>> (FRAC_BITS - 1)) + 1) >>> 1);
    dy_rd  = DR_W'(((t3_dy_r >>> (FRAC_BITS - 1)) + 1) >>> 1);
    quo    = Q_W'(t3_qp_r >>> RECIP_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (en[T4]) begin
      t4_su_r  <= VSUM_W'(sbt.u) + VSUM_W'(gfu_rd) - VSUM_W'(t3_duu_r);
      t4_sv_r  <= VSUM_W'(sbt.v) + VSUM_W'(gfv_rd) - VSUM_W'(t3_dvv_r);
      t4_sr_r  <= VSUM_W'(sbt.r) - VSUM_W'(glf_rd) - VSUM_W'(gwd_rd) - VSUM_W'(t3_drr_r);
      t4_sx_r  <= PSUM_W'(sbt.px) + PSUM_W'(dx_rd);
      t4_sy_r  <= PSUM_W'(sbt.py) + PSUM_W'(dy_rd);
      t4_rem_r <= RM_W'(t3_b_r) - RM_W'(quo) * TP_R;
    end
  end

  // T5: saturate and finish the heading wrap into the output register
  logic signed [VSUM_W-1:0] su_sat, sv_sat, sr_sat;
  logic signed [PSUM_W-1:0] sx_sat, sy_sat;
  logic signed [RM_W-1:0]   rem_fix;

  always_comb begin
    su_sat = (t4_su_r > V_HI) ? V_HI : ((t4_su_r < V_LO) ? V_LO : t4_su_r);
    sv_sat = (t4_sv_r > V_HI) ? V_HI : ((t4_sv_r < V_LO) ? V_LO : t4_sv_r);
    sr_sat = (t4_sr_r > V_HI) ? V_HI : ((t4_sr_r < V_LO) ? V_LO : t4_sr_r);
    sx_sat = (t4_sx_r > P_HI) ? P_HI : ((t4_sx_r < P_LO) ? P_LO : t4_sx_r);
    sy_sat = (t4_sy_r > P_HI) ? P_HI : ((t4_sy_r < P_LO) ? P_LO : t4_sy_r);
    // quotient estimate is off by at most one either way
    if (t4_rem_r < 0) begin
      rem_fix = t4_rem_r + TP_R;
    end else if (t4_rem_r >= TP_R) begin
      rem_fix = t4_rem_r - TP_R;
    end else begin
      rem_fix = t4_rem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[T5]) begin
      out_next_pos_x     <= POS_W'(sx_sat);
      out_next_pos_y     <= POS_W'(sy_sat);
      out_next_heading   <= HEAD_W'(rem_fix - P_R);
      out_next_surge_vel <= VEL_W'(su_sat);
      out_next_sway_vel  <= VEL_W'(sv_sat);
      out_next_yaw_rate  <= VEL_W'(sr_sat);
    end
  end

endmodule

// ===== rtl/core/tbd_checker.sv =====
// ---------------------------------------------------------------------------
// Twin thruster boat dynamics port checker
// Watches the top-level handshakes and the wrapped heading over time.
// ---------------------------------------------------------------------------
module tbd_checker
  import tbd_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [POS_W-1:0]  out_next_pos_x,
  input logic signed [HEAD_W-1:0] out_next_heading
);

  localparam logic signed [HEAD_W-1:0] P_H = HEAD_W'(P_FIX);

  // Nothing leaves the pipe in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // Input backpressure only comes from a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // A held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_next_pos_x)
                               && $stable(out_next_heading))
    else $error("stalled result changed");

  // Every delivered heading is wrapped into [-pi, pi)
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_next_heading >= -P_H) && (out_next_heading < P_H))
    else $error("heading out of wrap range");

endmodule

bind twin_thruster_boat_dynamics_step_top tbd_checker u_tbd_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Twin thruster boat dynamics step testbench
// Drives vessel states and thruster commands through the step pipeline under
// several gain settings, predicts each next state with an independent
// fixed-point CORDIC and Euler model, and checks every result in order.
// ---------------------------------------------------------------------------
module tb;
  import tbd_pkg::*;

  localparam int NUM_CFG     = 8;
  localparam int WATCH_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 40;
  localparam int MAX_PRINTS  = 40;
  localparam longint PI_Q = (64'sd3373259426 + (64'sd1 <<< 13)) >>> 14;

  typedef struct {
    logic signed [POS_W-1:0]  px, py;
    logic signed [HEAD_W-1:0] h;
    logic signed [VEL_W-1:0]  u, v, r;
    logic signed [THR_W-1:0]  tl, tr;
    logic signed [SWV_W-1:0]  al, ar;
  } vessel_cmd_t;

  typedef struct {
    logic signed [POS_W-1:0]  px, py;
    logic signed [HEAD_W-1:0] h;
    logic signed [VEL_W-1:0]  u, v, r;
  } vessel_state_t;

  // -------------------------------------------------------------------------
  // Scoreboard: gain registers, next-state predictor, pending next states
  // -------------------------------------------------------------------------
  class step_scoreboard;
    longint gains[NUM_CFG];
    vessel_state_t pending[$];
    int errors;
    int checked;

    function new();
      gains = '{6554, 32768, 32768, 220415, 44083, 1193, 1199, 17618};
      errors = 0;
      checked = 0;
    endfunction

    function void set_gain(cfg_reg_t idx, logic [CFG_W-1:0] val);
      if (idx == REG_STEP_TIME || idx >= REG_SURGE_DECAY)
        gains[idx] = longint'(val[15:0]);
      else
        gains[idx] = longint'(val);
    endfunction

    function longint rnd(longint val, int s);
      return (val + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function longint clamp(longint val, int w);
      longint hi;
      hi = (64'sd1 <<< (w - 1)) - 1;
      if (val > hi) return hi;
      if (val < -hi - 1) return -hi - 1;
      return val;
    endfunction

    function longint wrap_pi(longint a);
      longint m;
      m = (a + PI_Q) % (2 * PI_Q);
      if (m < 0) m += 2 * PI_Q;
      return m - PI_Q;
    endfunction

    // Rotation CORDIC in Q2.30 with half-turn fold
    function void rotate(longint a, output longint s, output longint c);
      longint z, x, y, xs, ys;
      bit flip;
      z = wrap_pi(a) <<< 14;
      x = 64'sd652032874;
      y = 0;
      flip = 0;
      if (z > 64'sd1686629713) begin
        z -= 64'sd3373259426;
        flip = 1;
      end else if (z < -64'sd1686629713) begin
        z += 64'sd3373259426;
        flip = 1;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= longint'(ATAN_Q30[i]);
        end else begin
          x += ys; y -= xs; z += longint'(ATAN_Q30[i]);
        end
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
    endfunction

    function vessel_state_t predict_step(vessel_cmd_t c);
      vessel_state_t n;
      longint sh, ch, sl, cl, sr, cr, fx, fy, fd, xd, yd;
      longint u, v, r, tl, tr;
      u = longint'(c.u); v = longint'(c.v); r = longint'(c.r);
      tl = longint'(c.tl); tr = longint'(c.tr);
      rotate(longint'(c.h), sh, ch);
      rotate(longint'(c.al), sl, cl);
      rotate(longint'(c.ar), sr, cr);
      fx = rnd(tl * cl + tr * cr, 15);
      fy = rnd(tl * sl + tr * sr, 15);
      fd = rnd(tl * cl - tr * cr, 15);
      n.u = VEL_W'(clamp(u + rnd(gains[1] * fx, 30) - rnd(gains[5] * u, FRAC_BITS),
                         VEL_W));
      n.v = VEL_W'(clamp(v + rnd(gains[2] * fy, 30) - rnd(gains[6] * v, FRAC_BITS),
                         VEL_W));
      n.r = VEL_W'(clamp(r - rnd(gains[3] * fy, 30) - rnd(gains[4] * fd, 30)
                         - rnd(gains[7] * r, FRAC_BITS), VEL_W));
      xd = rnd(u * ch - v * sh, 30);
      yd = rnd(u * sh + v * ch, 30);
      n.px = POS_W'(clamp(longint'(c.px) + rnd(gains[0] * xd, FRAC_BITS), POS_W));
      n.py = POS_W'(clamp(longint'(c.py) + rnd(gains[0] * yd, FRAC_BITS), POS_W));
      n.h = HEAD_W'(wrap_pi(longint'(c.h) + rnd(gains[0] * r, FRAC_BITS)));
      return n;
    endfunction

    function void note_input(vessel_cmd_t c);
      pending.insert(pending.size(), predict_step(c));
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      if (errors <= MAX_PRINTS)
        $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    endtask

    task check_result(vessel_state_t got);
      vessel_state_t want;
      if (pending.size() == 0) begin
        report("unexpected result", 1, 0);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.px != want.px) report("next_pos_x", longint'(got.px), longint'(want.px));
      if (got.py != want.py) report("next_pos_y", longint'(got.py), longint'(want.py));
      if (got.h != want.h) report("next_heading", longint'(got.h), longint'(want.h));
      if (got.u != want.u) report("next_surge_vel", longint'(got.u), longint'(want.u));
      if (got.v != want.v) report("next_sway_vel", longint'(got.v), longint'(want.v));
      if (got.r != want.r) report("next_yaw_rate", longint'(got.r), longint'(want.r));
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, in_stall;
  logic signed [POS_W-1:0]  in_pos_x = '0, in_pos_y = '0;
  logic signed [HEAD_W-1:0] in_heading = '0;
  logic signed [VEL_W-1:0]  in_surge_vel = '0, in_sway_vel = '0, in_yaw_rate = '0;
  logic signed [THR_W-1:0]  in_left_thrust = '0, in_right_thrust = '0;
  logic signed [SWV_W-1:0]  in_left_angle = '0, in_right_angle = '0;
  logic out_valid, out_stall = 0;
  logic signed [POS_W-1:0]  out_next_pos_x, out_next_pos_y;
  logic signed [HEAD_W-1:0] out_next_heading;
  logic signed [VEL_W-1:0]  out_next_surge_vel, out_next_sway_vel, out_next_yaw_rate;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  step_scoreboard sb = new();
  int idle_pct = 26;
  int stall_pct = 26;
  int sent = 0;
  int quiet_cycles = 0;

  twin_thruster_boat_dynamics_step_top i_dut (.*);

  // 12 ns clock
  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // Check results, toggle back-pressure, watch for a hang
  always @(posedge clk) begin
    vessel_state_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.px = out_next_pos_x; got.py = out_next_pos_y; got.h = out_next_heading;
      got.u = out_next_surge_vel; got.v = out_next_sway_vel; got.r = out_next_yaw_rate;
      sb.check_result(got);
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCH_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task write_gain(cfg_reg_t idx, logic [CFG_W-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_gain(idx, val);
    @(posedge clk);
  endtask

  // Hold valid until the transfer, idling at random before it
  task send(vessel_cmd_t c);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_pos_x <= c.px; in_pos_y <= c.py; in_heading <= c.h;
    in_surge_vel <= c.u; in_sway_vel <= c.v; in_yaw_rate <= c.r;
    in_left_thrust <= c.tl; in_right_thrust <= c.tr;
    in_left_angle <= c.al; in_right_angle <= c.ar;
    do @(posedge clk); while (in_stall);
    sb.note_input(c);
    sent++;
  endtask

  function vessel_cmd_t random_cmd();
    vessel_cmd_t c;
    c.px = $urandom; c.py = $urandom;
    c.tl = THR_W'($urandom); c.tr = THR_W'($urandom);
    if ($urandom_range(3) == 0) begin
      // raw fields, heading beyond pi
      c.h = HEAD_W'($urandom); c.u = VEL_W'($urandom);
      c.v = VEL_W'($urandom); c.r = VEL_W'($urandom);
      c.al = SWV_W'($urandom); c.ar = SWV_W'($urandom);
    end else begin
      c.h = HEAD_W'(int'($urandom_range(411774)) - 205887);
      c.u = VEL_W'(int'($urandom_range(2000000)) - 1000000);
      c.v = VEL_W'(int'($urandom_range(2000000)) - 1000000);
      c.r = VEL_W'(int'($urandom_range(400000)) - 200000);
      c.al = SWV_W'(int'($urandom_range(102944)) - 51472);
      c.ar = SWV_W'(int'($urandom_range(102944)) - 51472);
    end
    return c;
  endfunction

  function vessel_cmd_t cmd(longint px, longint py, longint h, longint u, longint v,
                            longint r, longint tl, longint tr, longint al, longint ar);
    vessel_cmd_t c;
    c.px = POS_W'(px); c.py = POS_W'(py); c.h = HEAD_W'(h);
    c.u = VEL_W'(u); c.v = VEL_W'(v); c.r = VEL_W'(r);
    c.tl = THR_W'(tl); c.tr = THR_W'(tr); c.al = SWV_W'(al); c.ar = SWV_W'(ar);
    return c;
  endfunction

  task run_directed();
    send(cmd(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(cmd(32'sh7fffffff, 32'sh7fffffff, 0, 8388607, 8388607, 8388607,
             32767, 32767, 0, 0));
    send(cmd(-32'sh80000000, -32'sh80000000, 0, -8388608, -8388608, -8388608,
             -32768, -32768, 0, 0));
    send(cmd(0, 0, 205887, 0, 0, 8388607, 0, 0, 51472, -51472));
    send(cmd(0, 0, -205887, 0, 0, -8388608, 0, 0, -51472, 51472));
    send(cmd(100, -100, -205888, 65536, -65536, 0, 32767, -32768, 51472, 51472));
    send(cmd(-1, 1, -262144, 65536, 65536, 65536, -32768, 32767, -65536, 65535));
    send(cmd(7, 9, 262143, -65536, 65536, -65536, 16384, 16384, 65535, -65536));
    send(cmd(32'sh7fff0000, -32'sh7fff0000, 102944, 8388607, -8388608, 0,
             32767, 32767, 102944, -102944));
    send(cmd(-32'sh7fff0000, 32'sh7fff0000, -102944, -8388608, 8388607, 0,
             -32768, -32768, -102944, 102944));
    send(cmd(0, 0, 51472, 300000, 300000, 100000, 32767, 32767, 25736, 25736));
    send(cmd(0, 0, -51472, -300000, 300000, -100000, 32767, -32768, -25736, 25736));
    send(cmd(0, 0, 205887, 0, 0, 4000000, 0, 0, 0, 0));
    send(cmd(0, 0, -205887, 0, 0, -4000000, 0, 0, 0, 0));
    send(cmd(0, 0, 0, 0, 0, 0, 32767, 0, 0, 51472));
    send(cmd(0, 0, 0, 0, 0, 0, 0, -32768, -51472, 0));
  endtask

  // Let the pipe drain before touching the gain registers
  task drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  initial begin
    int phase_items;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    for (int phase = 0; phase < 5; phase++) begin
      for (int g = 0; g < NUM_CFG; g++) begin
        logic [CFG_W-1:0] val;
        case (phase)
          0: val = CFG_W'(sb.gains[g]);
          1: val = '1;
          2: val = '0;
          default: val = CFG_W'($urandom);
        endcase
        write_gain(cfg_reg_t'(g), val);
      end
      if (phase < 3) run_directed();
      // second phase runs a stretch without any idling
      idle_pct = (phase == 1) ? 0 : 26;
      stall_pct = (phase == 1) ? 0 : 26;
      phase_items = 200;
      for (int k = 0; k < phase_items; k++) send(random_cmd());
      idle_pct = 26;
      stall_pct = 26;
      drain();
    end
    $display("Sent %0d vessel steps over five gain settings (defaults, max, zero, random)",
             sent);
    $display("Checked %0d next states, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/tbd_pkg.sv
rtl/core/tbd_cordic.sv
rtl/core/twin_thruster_boat_dynamics_step_top.sv
rtl/core/tbd_checker.sv
tb/tb.sv
